// ===== rtl/sts_pkg.sv =====
`default_nettype none

package sts_pkg;

    localparam int unsigned VAL_W   = 40;
    localparam int unsigned WGT_W   = 32;
    localparam int unsigned DELTA_W = 33;
    localparam int unsigned EVT_W   = 8;
    localparam int unsigned IDX_W   = 8;

    typedef enum logic {
        KIND_UPDATE = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    localparam logic [WGT_W-1:0] LEAF_MAX = {WGT_W{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/sts_if.sv =====
`default_nettype none

interface sts_in_if;
    import sts_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [IDX_W-1:0]          leaf_index;
    logic signed [DELTA_W-1:0] delta;
    logic [VAL_W-1:0]          draw;

    modport source (output valid, kind, leaf_index, delta, draw, input ready);
    modport sink   (input valid, kind, leaf_index, delta, draw, output ready);
endinterface

interface sts_out_if;
    import sts_pkg::*;

    logic             valid;
    logic             ready;
    logic [EVT_W-1:0] event_index;
    logic [VAL_W-1:0] total;
    logic             draw_out_of_range;
    logic             leaf_clamped;

    modport source (output valid, event_index, total, draw_out_of_range, leaf_clamped,
                    input ready);
    modport sink   (input valid, event_index, total, draw_out_of_range, leaf_clamped,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/sts_ram.sv =====
`default_nettype none

module sts_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 512
) (
    input  wire                         i_clk,
    input  wire                         i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire [WIDTH-1:0]             i_wr_data,
    input  wire                         i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [WIDTH-1:0]            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/sum_tree_discrete_sampler_unit.sv =====
// Weighted sampler over a sum tree of 2^LEVELS Q16.16 leaf weights.
// Input channel i_in (valid/ready): kind 0 adds a signed delta to leaf
// leaf_index, saturating the leaf to 0..2^32-1 and adding the applied change
// to every ancestor; kind 1 walks down from the root with draw and returns
// the leaf reached. A draw not below the total flags draw_out_of_range and
// returns the rightmost leaf.
// Output channel o_out (valid/ready): one beat per input beat, carrying the
// chosen or updated leaf, the root total after the item and the two flags.
// All node sums live in one synchronous RAM (one write, one read port,
// registered read data); each tree level of an update costs one RAM
// read-modify-write. An update runs S_UPD_LEAF, then S_UPD_ANC per
// ancestor, then S_OUT; a sample runs S_SMP_ROOT, S_SMP_WALK per level,
// then S_OUT, skipping the walk for an out-of-range draw. One item is in
// flight at a time: a new item is accepted only after the last one has
// left the engine. After reset the block sweeps all 2^(LEVELS+1) RAM
// entries to zero, one entry per cycle, with i_in.ready low.
// A stalled receiver holds the output beat in its register; the next item
// is still accepted and processed, and only its completion waits for the
// output register to free up.
`default_nettype none

module sum_tree_discrete_sampler_unit
    import sts_pkg::*;
#(
    parameter int unsigned LEVELS = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sts_in_if.sink       i_in,
    sts_out_if.source    o_out
);

    localparam int unsigned ADDR_W = LEVELS + 1;
    localparam int unsigned DEPTH  = 1 << ADDR_W;
    localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int unsigned EXT_W  = (LEVELS > IDX_W) ? LEVELS : IDX_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_LEAF,
        S_UPD_ANC,
        S_SMP_ROOT,
        S_SMP_WALK,
        S_OUT
    } t_state;

    t_state                    r_state, n_state;
    logic [ADDR_W-1:0]         r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]         r_pos, n_pos;
    logic [LVL_W-1:0]          r_lvl, n_lvl;
    logic [LEVELS-1:0]         r_leaf, n_leaf;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic [VAL_W-1:0]          r_draw, n_draw;
    logic [VAL_W-1:0]          r_change, n_change;
    logic [VAL_W-1:0]          r_total, n_total;
    logic                      r_oor, n_oor;
    logic                      r_clamp, n_clamp;

    logic                      r_out_valid, n_out_valid;
    logic [EVT_W-1:0]          r_out_event, n_out_event;
    logic [VAL_W-1:0]          r_out_total, n_out_total;
    logic                      r_out_oor, n_out_oor;
    logic                      r_out_clamp, n_out_clamp;

    logic                      w_wr_en;
    logic [ADDR_W-1:0]         w_wr_addr;
    logic [VAL_W-1:0]          w_wr_data;
    logic                      w_rd_en;
    logic [ADDR_W-1:0]         w_rd_addr;
    logic [VAL_W-1:0]          w_rd_data;

    logic                      w_accept;
    logic [EXT_W-1:0]          w_leaf_ext;
    logic [EXT_W-1:0]          w_evt_ext;
    logic signed [WGT_W+2:0]   w_sum;
    logic [WGT_W-1:0]          w_new_w;
    logic                      w_sat;
    logic [VAL_W:0]            w_diff;
    logic [VAL_W-1:0]          w_anc_sum;
    logic [ADDR_W-1:0]         w_walk_pos;

    sts_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_leaf_ext = EXT_W'(i_in.leaf_index);
    assign w_evt_ext  = EXT_W'(r_leaf);

    // leaf saturation
    assign w_sum = $signed({3'b000, w_rd_data[WGT_W-1:0]}) + (WGT_W+3)'(r_delta);
    always_comb begin
        w_sat   = 1'b0;
        w_new_w = w_sum[WGT_W-1:0];
        if (w_sum[WGT_W+2]) begin
            w_sat   = 1'b1;
            w_new_w = '0;
        end else if (w_sum[WGT_W+1:WGT_W] != 2'b00) begin
            w_sat   = 1'b1;
            w_new_w = LEAF_MAX;
        end
    end

    assign w_anc_sum  = w_rd_data + r_change;
    assign w_diff     = {1'b0, r_draw} - {1'b0, w_rd_data};
    assign w_walk_pos = {r_pos[ADDR_W-2:0], ~w_diff[VAL_W]};

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_pos       = r_pos;
        n_lvl       = r_lvl;
        n_leaf      = r_leaf;
        n_delta     = r_delta;
        n_draw      = r_draw;
        n_change    = r_change;
        n_total     = r_total;
        n_oor       = r_oor;
        n_clamp     = r_clamp;
        n_out_valid = r_out_valid;
        n_out_event = r_out_event;
        n_out_total = r_out_total;
        n_out_oor   = r_out_oor;
        n_out_clamp = r_out_clamp;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_pos;
        w_wr_data   = w_anc_sum;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_pos;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_data  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == {ADDR_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_leaf  = w_leaf_ext[LEVELS-1:0];
                    n_delta = i_in.delta;
                    n_draw  = i_in.draw;
                    n_oor   = 1'b0;
                    n_clamp = 1'b0;
                    n_lvl   = '0;
                    w_rd_en = 1'b1;
                    if (t_kind'(i_in.kind) == KIND_SAMPLE) begin
                        n_pos     = ADDR_W'(1);
                        w_rd_addr = ADDR_W'(1);
                        n_state   = S_SMP_ROOT;
                    end else begin
                        n_pos     = {1'b1, w_leaf_ext[LEVELS-1:0]};
                        w_rd_addr = {1'b1, w_leaf_ext[LEVELS-1:0]};
                        n_state   = S_UPD_LEAF;
                    end
                end
            end
            S_UPD_LEAF: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos;
                w_wr_data = VAL_W'(w_new_w);
                n_clamp   = w_sat;
                n_change  = VAL_W'(w_new_w) - VAL_W'(w_rd_data[WGT_W-1:0]);
                n_pos     = r_pos >> 1;
                w_rd_en   = 1'b1;
                w_rd_addr = r_pos >> 1;
                n_state   = S_UPD_ANC;
            end
            S_UPD_ANC: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos;
                w_wr_data = w_anc_sum;
                if (r_pos == ADDR_W'(1)) begin
                    n_total = w_anc_sum;
                    n_state = S_OUT;
                end else begin
                    n_pos     = r_pos >> 1;
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_pos >> 1;
                end
            end
            S_SMP_ROOT: begin
                n_total = w_rd_data;
                if (r_draw >= w_rd_data) begin
                    n_oor   = 1'b1;
                    n_leaf  = {LEVELS{1'b1}};
                    n_state = S_OUT;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = ADDR_W'(2);
                    n_state   = S_SMP_WALK;
                end
            end
            S_SMP_WALK: begin
                n_pos = w_walk_pos;
                if (!w_diff[VAL_W]) begin
                    n_draw = w_diff[VAL_W-1:0];
                end
                if (r_lvl == LVL_W'(LEVELS - 1)) begin
                    n_leaf  = w_walk_pos[LEVELS-1:0];
                    n_state = S_OUT;
                end else begin
                    n_lvl     = r_lvl + LVL_W'(1);
                    w_rd_en   = 1'b1;
                    w_rd_addr = {w_walk_pos[ADDR_W-2:0], 1'b0};
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_event = w_evt_ext[EVT_W-1:0];
                    n_out_total = r_total;
                    n_out_oor   = r_oor;
                    n_out_clamp = r_clamp;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_pos       <= n_pos;
        r_lvl       <= n_lvl;
        r_leaf      <= n_leaf;
        r_delta     <= n_delta;
        r_draw      <= n_draw;
        r_change    <= n_change;
        r_total     <= n_total;
        r_oor       <= n_oor;
        r_clamp     <= n_clamp;
        r_out_event <= n_out_event;
        r_out_total <= n_out_total;
        r_out_oor   <= n_out_oor;
        r_out_clamp <= n_out_clamp;
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.event_index       = r_out_event;
    assign o_out.total             = r_out_total;
    assign o_out.draw_out_of_range = r_out_oor;
    assign o_out.leaf_clamped      = r_out_clamp;

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && w_rd_en) |-> (w_wr_addr != w_rd_addr))
        else $error("RAM read and write hit the same node");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_out.ready) |=> (r_state == S_OUT))
        else $error("result left the engine while output register was full");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_oor && r_out_clamp))
        else $error("sample and update flags both set");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !(r_state == S_UPD_LEAF || r_state == S_SMP_ROOT))
        else $error("item started during RAM clear");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
    import sts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS       = 8;
    localparam int NUM_LEAVES   = 1 << LEVELS;
    localparam int NUM_RANDOM   = 1500;
    localparam int PAUSE_AT     = 1000;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 4 * (LEVELS + 3);
    localparam int CYCLE_LIMIT  = 500000;

    typedef enum {
        DRAW_LITERAL,
        DRAW_BELOW_TOTAL,
        DRAW_LAST_UNIT,
        DRAW_AT_TOTAL
    } t_draw_mode;

    typedef struct {
        t_kind                     kind;
        logic [IDX_W-1:0]          leaf;
        logic signed [DELTA_W-1:0] delta;
        logic [VAL_W-1:0]          draw;
        t_draw_mode                mode;
    } t_tree_op;

    typedef struct {
        logic [EVT_W-1:0] event_index;
        logic [VAL_W-1:0] total;
        logic             draw_out_of_range;
        logic             leaf_clamped;
    } t_tree_result;

    logic i_clk;
    logic i_rst_n;

    sts_in_if  in_if ();
    sts_out_if out_if ();

    sum_tree_discrete_sampler_unit #(
        .LEVELS (LEVELS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow sum tree in heap order, root at 1
    logic [VAL_W-1:0] tree_sum [0:2*NUM_LEAVES-1];

    t_tree_op     op_q [$];
    t_tree_result awaited_q [$];

    int total_ops;
    int offered_count;
    int sent_count;
    int recv_count;
    int err_count;
    int hold_left;
    bit hold_done;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic t_tree_result tree_predict(logic kind, logic [IDX_W-1:0] leaf,
                                                  logic signed [DELTA_W-1:0] delta,
                                                  logic [VAL_W-1:0] draw);
        t_tree_result r;
        int unsigned  pos;
        longint       old_w;
        longint       new_w;
        logic [VAL_W-1:0] chg;
        logic [VAL_W-1:0] rest;
        logic [VAL_W-1:0] left;
        r.event_index       = leaf;
        r.draw_out_of_range = 1'b0;
        r.leaf_clamped      = 1'b0;
        if (kind == KIND_UPDATE) begin
            pos   = NUM_LEAVES + leaf;
            old_w = longint'({32'd0, tree_sum[pos][WGT_W-1:0]});
            new_w = old_w + longint'(delta);
            if (new_w < 0) begin
                new_w = 0;
                r.leaf_clamped = 1'b1;
            end else if (new_w > longint'({32'd0, LEAF_MAX})) begin
                new_w = longint'({32'd0, LEAF_MAX});
                r.leaf_clamped = 1'b1;
            end
            chg = VAL_W'(new_w - old_w);
            tree_sum[pos] = VAL_W'(new_w);
            pos = pos >> 1;
            while (pos >= 1) begin
                tree_sum[pos] = tree_sum[pos] + chg;
                pos = pos >> 1;
            end
        end else if (draw >= tree_sum[1]) begin
            r.draw_out_of_range = 1'b1;
            r.event_index       = EVT_W'(NUM_LEAVES - 1);
        end else begin
            rest = draw;
            pos  = 1;
            repeat (LEVELS) begin
                left = tree_sum[2*pos];
                if (rest < left) begin
                    pos = 2 * pos;
                end else begin
                    rest = rest - left;
                    pos  = 2 * pos + 1;
                end
            end
            r.event_index = EVT_W'(pos - NUM_LEAVES);
        end
        r.total = tree_sum[1];
        return r;
    endfunction

    function automatic t_tree_op mk_update(int leaf, logic signed [DELTA_W-1:0] delta);
        t_tree_op op;
        op.kind  = KIND_UPDATE;
        op.leaf  = IDX_W'(leaf);
        op.delta = delta;
        op.draw  = {8'($urandom_range(255, 0)), $urandom};
        op.mode  = DRAW_LITERAL;
        return op;
    endfunction

    function automatic t_tree_op mk_sample(t_draw_mode mode, logic [VAL_W-1:0] draw);
        t_tree_op op;
        op.kind  = KIND_SAMPLE;
        op.leaf  = IDX_W'($urandom_range(NUM_LEAVES - 1, 0));
        op.delta = {1'($urandom_range(1, 0)), $urandom};
        op.draw  = draw;
        op.mode  = mode;
        return op;
    endfunction

    function automatic int idle_phase();
        if (sent_count < total_ops / 3)
            return 0;
        else if (sent_count < (2 * total_ops) / 3)
            return 1;
        return 2;
    endfunction

    function automatic int send_idle_pct();
        case (idle_phase())
            0: return 30;
            1: return 80;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_phase())
            0: return 80;
            1: return 30;
            default: return 0;
        endcase
    endfunction

    task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // input driver
    always @(negedge i_clk) begin : op_driver
        t_tree_op    op;
        logic [63:0] r64;
        if (in_if.valid && sent_count != offered_count) begin
            // beat still waiting for ready
        end else if (op_q.size() == 0 ||
                     (offered_count == PAUSE_AT && awaited_q.size() != 0) ||
                     $urandom_range(99, 0) < send_idle_pct()) begin
            in_if.valid <= 1'b0;
        end else begin
            op = op_q.pop_front();
            case (op.mode)
                DRAW_BELOW_TOTAL: begin
                    r64 = {$urandom, $urandom};
                    op.draw = (tree_sum[1] == '0) ? '0 : VAL_W'(r64 % tree_sum[1]);
                end
                DRAW_LAST_UNIT: op.draw = tree_sum[1] - 1'b1;
                DRAW_AT_TOTAL:  op.draw = tree_sum[1];
                default: ;
            endcase
            in_if.kind       <= op.kind;
            in_if.leaf_index <= op.leaf;
            in_if.delta      <= op.delta;
            in_if.draw       <= op.draw;
            in_if.valid      <= 1'b1;
            offered_count++;
        end
    end

    // output ready, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!hold_done && recv_count >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct());
        end
    end

    // accepted beats feed the predictor, result beats are checked in order
    always @(posedge i_clk) begin : beat_monitor
        t_tree_result want;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            awaited_q.push_back(tree_predict(in_if.kind, in_if.leaf_index, in_if.delta,
                                             in_if.draw));
            sent_count++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            recv_count++;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected result beat, index %0d total %0h", $time,
                         out_if.event_index, out_if.total);
                err_count++;
            end else begin
                want = awaited_q.pop_front();
                report_field("event_index", 64'(want.event_index),
                             64'(out_if.event_index));
                report_field("total", 64'(want.total), 64'(out_if.total));
                report_field("draw_out_of_range", 64'(want.draw_out_of_range),
                             64'(out_if.draw_out_of_range));
                report_field("leaf_clamped", 64'(want.leaf_clamped),
                             64'(out_if.leaf_clamped));
            end
        end
    end

    initial begin : watchdog
        int n;
        n = 0;
        while (n < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int       n;
        int       r;
        int       burst;
        int       leaf;
        logic signed [DELTA_W-1:0] d;

        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_UPDATE;
        in_if.leaf_index = '0;
        in_if.delta      = '0;
        in_if.draw       = '0;
        out_if.ready     = 1'b0;
        offered_count    = 0;
        sent_count       = 0;
        recv_count       = 0;
        err_count        = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        for (int i = 0; i < 2 * NUM_LEAVES; i++)
            tree_sum[i] = '0;

        // directed: empty tree, saturation both ways, draw boundaries
        op_q.push_back(mk_sample(DRAW_LITERAL, '0));
        op_q.push_back(mk_sample(DRAW_LITERAL, {VAL_W{1'b1}}));
        op_q.push_back(mk_update(0, 33'sd1));
        op_q.push_back(mk_update(255, 33'sh0_FFFF_FFFF));
        op_q.push_back(mk_sample(DRAW_AT_TOTAL, '0));
        op_q.push_back(mk_sample(DRAW_LAST_UNIT, '0));
        op_q.push_back(mk_sample(DRAW_LITERAL, '0));
        op_q.push_back(mk_update(255, 33'sd5));
        op_q.push_back(mk_update(0, -33'sd5));
        op_q.push_back(mk_update(128, 33'sh1_0000_0000));
        op_q.push_back(mk_update(7, 33'sd0));
        op_q.push_back(mk_update(1, 33'sh0_0001_0000));
        op_q.push_back(mk_update(254, 33'sh0_FFFF_FFFF));
        op_q.push_back(mk_update(3, 33'sh1_0000_0001));
        op_q.push_back(mk_sample(DRAW_BELOW_TOTAL, '0));
        op_q.push_back(mk_sample(DRAW_LAST_UNIT, '0));
        op_q.push_back(mk_sample(DRAW_LITERAL, {VAL_W{1'b1}}));
        op_q.push_back(mk_update(255, 33'sh1_0000_0001));
        op_q.push_back(mk_sample(DRAW_LAST_UNIT, '0));
        op_q.push_back(mk_update(127, 33'sh0_FFFF_FFFF));
        op_q.push_back(mk_update(129, 33'sh0_FFFF_FFFF));
        op_q.push_back(mk_sample(DRAW_BELOW_TOTAL, '0));
        op_q.push_back(mk_sample(DRAW_BELOW_TOTAL, '0));

        n = 0;
        while (n < NUM_RANDOM) begin
            r = $urandom_range(99, 0);
            if (r < 4) begin
                // burst of full-scale updates to push the total toward 2^40
                burst = $urandom_range(12, 4);
                repeat (burst) begin
                    op_q.push_back(mk_update($urandom_range(NUM_LEAVES - 1, 0),
                                             33'sh0_FFFF_FFFF));
                    n++;
                end
            end else if (r < 52) begin
                leaf = ($urandom_range(9, 0) < 3) ? $urandom_range(7, 0)
                                                  : $urandom_range(NUM_LEAVES - 1, 0);
                r = $urandom_range(99, 0);
                if (r < 35) begin
                    d = {1'($urandom_range(1, 0)), $urandom};
                end else if (r < 60) begin
                    d = DELTA_W'($urandom_range(1 << 20, 0));
                end else if (r < 80) begin
                    d = DELTA_W'($urandom_range(1 << 20, 1));
                    d = -d;
                end else if (r < 90) begin
                    d = {1'b0, $urandom};
                end else begin
                    case ($urandom_range(3, 0))
                        0: d = 33'sh0_FFFF_FFFF;
                        1: d = 33'sh1_0000_0000;
                        2: d = 33'sh1_0000_0001;
                        default: d = 33'sd0;
                    endcase
                end
                op_q.push_back(mk_update(leaf, d));
                n++;
            end else begin
                r = $urandom_range(99, 0);
                if (r < 75)
                    op_q.push_back(mk_sample(DRAW_BELOW_TOTAL, '0));
                else if (r < 80)
                    op_q.push_back(mk_sample(DRAW_LAST_UNIT, '0));
                else if (r < 85)
                    op_q.push_back(mk_sample(DRAW_AT_TOTAL, '0));
                else
                    op_q.push_back(mk_sample(DRAW_LITERAL,
                                             {8'($urandom_range(255, 0)), $urandom}));
                n++;
            end
        end
        total_ops = op_q.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (sent_count == total_ops);
        wait (awaited_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
